// ----- hw/rtl/tcgr_pkg.sv -----
package tcgr_pkg;

    localparam int GLYPH_COUNT      = 512;
    localparam int MAX_GLYPH_HEIGHT = 32;
    localparam int MAX_GLYPH_WIDTH  = 16;
    localparam int MAP_ENTRIES      = 256;
    localparam int MAX_COLS         = 512;
    localparam int MAX_ROWS         = 256;
    localparam int FONT_BYTES       = 32768;
    localparam int QUEUE_DEPTH      = 4;

    localparam int MAP_AW   = $clog2(MAP_ENTRIES);
    localparam int FONT_AW  = $clog2(FONT_BYTES);
    localparam int GLYPH_W  = $clog2(GLYPH_COUNT);
    localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        OP_MAP  = 2'd0,
        OP_FONT = 2'd1,
        OP_PUT  = 2'd2,
        OP_NONE = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        REG_FG_BG_RGB    = 3'd0,
        REG_COLOR_LAYOUT = 3'd1,
        REG_SCREEN_WIDTH = 3'd2,
        REG_BYTES_PER_PX = 3'd3,
        REG_GLYPH_WIDTH  = 3'd4,
        REG_GLYPH_HEIGHT = 3'd5,
        REG_TEXT_COLS    = 3'd6,
        REG_TEXT_ROWS    = 3'd7
    } t_reg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SET1,
        S_SET2,
        S_SET3,
        S_RD0,
        S_RD1,
        S_CAP
    } t_state;

    typedef struct packed {
        logic [47:0] fg_bg_rgb;
        logic [26:0] color_layout;
        logic [12:0] screen_width_px;
        logic [2:0]  bytes_per_pixel;
        logic [4:0]  glyph_width;
        logic [5:0]  glyph_height;
        logic [9:0]  text_cols;
        logic [8:0]  text_rows;
    } t_cfg;

    typedef struct packed {
        logic               is_put;
        logic [GLYPH_W-1:0] glyph;
        logic [FONT_AW-1:0] font_address;
        logic [7:0]         font_byte;
    } t_cmd;

    typedef struct packed {
        logic valid;
        logic ready;
    } t_hs;

endpackage

// ----- hw/rtl/tcgr_in_if.sv -----
interface tcgr_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [7:0] char_code;
    logic [8:0] glyph_number;
    logic [14:0] font_address;
    logic [7:0] font_byte;

    modport source (output valid, operation, char_code, glyph_number, font_address, font_byte,
                    input ready);
    modport sink   (input valid, operation, char_code, glyph_number, font_address, font_byte,
                    output ready);
endinterface

// ----- hw/rtl/tcgr_out_if.sv -----
interface tcgr_out_if;
    logic        valid;
    logic        ready;
    logic [26:0] byte_offset;
    logic [15:0] pixel_mask;
    logic [31:0] fg_word;
    logic [31:0] bg_word;
    logic        last;

    modport source (output valid, byte_offset, pixel_mask, fg_word, bg_word, last,
                    input ready);
    modport sink   (input valid, byte_offset, pixel_mask, fg_word, bg_word, last,
                    output ready);
endinterface

// ----- hw/rtl/tcgr_ram.sv -----
module tcgr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_q <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_q;
endmodule

// ----- hw/rtl/tcgr_front.sv -----
module tcgr_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    tcgr_in_if.sink             i_cmd,
    output tcgr_pkg::t_cmd      o_push_data,
    output tcgr_pkg::t_hs       o_push_hs_v,
    input  logic                i_push_ready
);
    logic [tcgr_pkg::MAP_ENTRIES-1:0] r_map_vld;
    logic                             r_s1_vld;
    logic                             r_s1_put;
    logic                             r_s1_hit;
    logic [tcgr_pkg::FONT_AW-1:0]     r_s1_addr;
    logic [7:0]                       r_s1_byte;
    logic [tcgr_pkg::GLYPH_W-1:0]     map_q;
    logic [tcgr_pkg::GLYPH_W-1:0]     glyph;
    tcgr_pkg::t_op                    op;
    logic                             accept;

    assign op           = tcgr_pkg::t_op'(i_cmd.operation);
    assign i_cmd.ready  = !r_s1_vld || i_push_ready;
    assign accept       = i_cmd.valid && i_cmd.ready;

    tcgr_ram #(
        .WIDTH (tcgr_pkg::GLYPH_W),
        .DEPTH (tcgr_pkg::MAP_ENTRIES)
    ) u_map (
        .i_clk   (i_clk),
        .i_en    (accept && (op == tcgr_pkg::OP_MAP || op == tcgr_pkg::OP_PUT)),
        .i_we    (op == tcgr_pkg::OP_MAP),
        .i_addr  (i_cmd.char_code[tcgr_pkg::MAP_AW-1:0]),
        .i_wdata (i_cmd.glyph_number),
        .o_rdata (map_q)
    );

    // entries never written read as glyph 0
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_vld <= '0;
            r_s1_vld  <= 1'b0;
        end else begin
            if (accept && op == tcgr_pkg::OP_MAP) begin
                r_map_vld[i_cmd.char_code[tcgr_pkg::MAP_AW-1:0]] <= 1'b1;
            end
            if (accept) begin
                r_s1_vld <= (op == tcgr_pkg::OP_FONT) || (op == tcgr_pkg::OP_PUT);
            end else if (i_push_ready) begin
                r_s1_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_put  <= (op == tcgr_pkg::OP_PUT);
            r_s1_hit  <= r_map_vld[i_cmd.char_code[tcgr_pkg::MAP_AW-1:0]];
            r_s1_addr <= i_cmd.font_address;
            r_s1_byte <= i_cmd.font_byte;
        end
    end

    always_comb begin
        glyph = r_s1_hit ? map_q : '0;
        if ({1'b0, glyph} >= (tcgr_pkg::GLYPH_W + 1)'(tcgr_pkg::GLYPH_COUNT)) begin
            glyph = '0;
        end
    end

    assign o_push_data.is_put       = r_s1_put;
    assign o_push_data.glyph        = glyph;
    assign o_push_data.font_address = r_s1_addr;
    assign o_push_data.font_byte    = r_s1_byte;
    assign o_push_hs_v.valid        = r_s1_vld;
    assign o_push_hs_v.ready        = i_push_ready;
endmodule

// ----- hw/rtl/tcgr_fifo.sv -----
module tcgr_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  tcgr_pkg::t_cmd i_data,
    input  tcgr_pkg::t_hs  i_push_hs,
    output logic           o_push_ready,
    output tcgr_pkg::t_cmd o_data,
    output logic           o_pop_valid,
    input  logic           i_pop_ready
);
    tcgr_pkg::t_cmd                r_ent [tcgr_pkg::QUEUE_DEPTH];
    logic [tcgr_pkg::QUEUE_AW-1:0] r_wp;
    logic [tcgr_pkg::QUEUE_AW-1:0] r_rp;
    logic [tcgr_pkg::QUEUE_AW:0]   r_cnt;
    logic                          push;
    logic                          pop;

    assign o_push_ready = r_cnt != (tcgr_pkg::QUEUE_AW + 1)'(tcgr_pkg::QUEUE_DEPTH);
    assign o_pop_valid  = r_cnt != '0;
    assign push         = i_push_hs.valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;
    assign o_data       = r_ent[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 1'b1;
            if (pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (tcgr_pkg::QUEUE_AW + 1)'(push) - (tcgr_pkg::QUEUE_AW + 1)'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_ent[r_wp] <= i_data;
    end
endmodule

// ----- hw/rtl/tcgr_back.sv -----
module tcgr_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  tcgr_pkg::t_cfg i_cfg,
    input  tcgr_pkg::t_cmd i_cmd,
    input  logic           i_cmd_valid,
    output logic           o_cmd_ready,
    tcgr_out_if.source     o_row
);
    tcgr_pkg::t_state r_state, n_state;

    logic [8:0]                   r_col;
    logic [7:0]                   r_row;
    logic [tcgr_pkg::GLYPH_W-1:0] r_glyph;
    logic [13:0]                  r_rh;
    logic [13:0]                  r_cw;
    logic [15:0]                  r_stride;
    logic [9:0]                   r_gb;
    logic [tcgr_pkg::FONT_AW-1:0] r_faddr;
    logic [26:0]                  r_off;
    logic [4:0]                   r_y;
    logic [7:0]                   r_b0;
    logic [31:0]                  r_fg;
    logic [31:0]                  r_bg;
    logic                         r_o_vld;
    logic [26:0]                  r_o_off;
    logic [15:0]                  r_o_mask;
    logic                         r_o_last;

    logic [4:0]                   w_c;
    logic [5:0]                   h_c;
    logic [9:0]                   cols_c;
    logic [8:0]                   rows_c;
    logic                         bpr2;
    logic [1:0]                   bpr;
    logic                         ram_en;
    logic                         ram_we;
    logic [tcgr_pkg::FONT_AW-1:0] ram_addr;
    logic [7:0]                   ram_q;
    logic                         emit;
    logic                         last_row;
    logic [15:0]                  row_cat;

    function automatic logic [31:0] f_encode(logic [23:0] rgb, logic [26:0] lay);
        logic [38:0] word;
        logic [8:0]  chunk;
        logic [15:0] msk;
        logic [7:0]  val;
        int          ch;
        word = '0;
        for (ch = 0; ch < 3; ch++) begin
            chunk = lay[9*ch +: 9];
            val   = rgb[16-8*ch +: 8];
            msk   = 16'((17'd1 << chunk[8:5]) - 17'd1);
            word  = word | (39'(val & msk[7:0]) << chunk[4:0]);
        end
        return word[31:0];
    endfunction

    always_comb begin
        if (i_cfg.glyph_width == '0) w_c = 5'd1;
        else if (i_cfg.glyph_width > 5'(tcgr_pkg::MAX_GLYPH_WIDTH))
            w_c = 5'(tcgr_pkg::MAX_GLYPH_WIDTH);
        else w_c = i_cfg.glyph_width;
        if (i_cfg.glyph_height == '0) h_c = 6'd1;
        else if (i_cfg.glyph_height > 6'(tcgr_pkg::MAX_GLYPH_HEIGHT))
            h_c = 6'(tcgr_pkg::MAX_GLYPH_HEIGHT);
        else h_c = i_cfg.glyph_height;
        cols_c = (i_cfg.text_cols > 10'(tcgr_pkg::MAX_COLS)) ? 10'(tcgr_pkg::MAX_COLS)
                                                             : i_cfg.text_cols;
        rows_c = (i_cfg.text_rows > 9'(tcgr_pkg::MAX_ROWS)) ? 9'(tcgr_pkg::MAX_ROWS)
                                                            : i_cfg.text_rows;
    end

    assign bpr2     = w_c > 5'd8;
    assign bpr      = bpr2 ? 2'd2 : 2'd1;
    assign emit     = (r_state == tcgr_pkg::S_CAP) && (!r_o_vld || o_row.ready);
    assign last_row = r_y == 5'(h_c - 6'd1);
    assign row_cat  = bpr2 ? {r_b0, ram_q} : {ram_q, 8'h00};

    tcgr_ram #(
        .WIDTH (8),
        .DEPTH (tcgr_pkg::FONT_BYTES)
    ) u_font (
        .i_clk   (i_clk),
        .i_en    (ram_en),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (i_cmd.font_byte),
        .o_rdata (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= tcgr_pkg::S_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state     = r_state;
        o_cmd_ready = 1'b0;
        ram_en      = 1'b0;
        ram_we      = 1'b0;
        ram_addr    = r_faddr;
        unique case (r_state)
            tcgr_pkg::S_IDLE: begin
                o_cmd_ready = 1'b1;
                ram_addr    = i_cmd.font_address;
                if (i_cmd_valid) begin
                    if (i_cmd.is_put) begin
                        n_state = tcgr_pkg::S_SET1;
                    end else begin
                        ram_en = 1'b1;
                        ram_we = 1'b1;
                    end
                end
            end
            tcgr_pkg::S_SET1: n_state = tcgr_pkg::S_SET2;
            tcgr_pkg::S_SET2: n_state = tcgr_pkg::S_SET3;
            tcgr_pkg::S_SET3: n_state = tcgr_pkg::S_RD0;
            tcgr_pkg::S_RD0: begin
                ram_en  = 1'b1;
                n_state = bpr2 ? tcgr_pkg::S_RD1 : tcgr_pkg::S_CAP;
            end
            tcgr_pkg::S_RD1: begin
                ram_en   = 1'b1;
                ram_addr = r_faddr + 1'b1;
                n_state  = tcgr_pkg::S_CAP;
            end
            tcgr_pkg::S_CAP: begin
                if (emit) n_state = last_row ? tcgr_pkg::S_IDLE : tcgr_pkg::S_RD0;
            end
            default: n_state = tcgr_pkg::S_IDLE;
        endcase
    end

    // cursor and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_o_vld <= 1'b0;
        end else begin
            if (emit) r_o_vld <= 1'b1;
            else if (o_row.ready) r_o_vld <= 1'b0;
            if (emit && last_row) begin
                if ({1'b0, r_col} + 10'd1 >= cols_c) begin
                    r_col <= '0;
                    if ({1'b0, r_row} + 9'd1 >= rows_c) r_row <= '0;
                    else r_row <= r_row + 8'd1;
                end else begin
                    r_col <= r_col + 9'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == tcgr_pkg::S_IDLE && i_cmd_valid) r_glyph <= i_cmd.glyph;
        if (r_state == tcgr_pkg::S_SET1) begin
            r_rh     <= 14'(r_row) * 14'(h_c);
            r_cw     <= 14'(r_col) * 14'(w_c);
            r_stride <= 16'(i_cfg.screen_width_px) * 16'(i_cfg.bytes_per_pixel);
            r_gb     <= 10'(r_glyph) * 10'(bpr);
            r_fg     <= f_encode(i_cfg.fg_bg_rgb[23:0], i_cfg.color_layout);
            r_bg     <= f_encode(i_cfg.fg_bg_rgb[47:24], i_cfg.color_layout);
        end
        if (r_state == tcgr_pkg::S_SET2) begin
            r_off   <= 27'(27'(r_rh) * 27'(i_cfg.screen_width_px) + 27'(r_cw));
            r_faddr <= tcgr_pkg::FONT_AW'(16'(r_gb) * 16'(h_c));
        end
        if (r_state == tcgr_pkg::S_SET3) begin
            r_off <= 27'(r_off * 27'(i_cfg.bytes_per_pixel));
            r_y   <= '0;
        end
        if (r_state == tcgr_pkg::S_RD1) r_b0 <= ram_q;
        if (emit) begin
            r_o_off  <= r_off;
            r_o_mask <= row_cat >> (5'd16 - w_c);
            r_o_last <= last_row;
            r_off    <= r_off + 27'(r_stride);
            r_faddr  <= r_faddr + tcgr_pkg::FONT_AW'(bpr);
            r_y      <= r_y + 5'd1;
        end
    end

    assign o_row.valid       = r_o_vld;
    assign o_row.byte_offset = r_o_off;
    assign o_row.pixel_mask  = r_o_mask;
    assign o_row.fg_word     = r_fg;
    assign o_row.bg_word     = r_bg;
    assign o_row.last        = r_o_last;
endmodule

// ----- hw/rtl/text_console_glyph_renderer_core.sv -----
// Channel   Dir  Modport  Transfer
// i_cmd     in   sink     map write, font byte write or character put
// o_row     out  source   one glyph row: offset, pixel mask, fg/bg words, last
// i_cfg_*   in   -        register write, one per cycle while i_cfg_we is high
//
// Map writes finish in the front end and never reach the back end; a font
// write is stored as it is popped in S_IDLE. A put runs S_SET1 to S_SET3,
// then per glyph row reads S_RD0 (and S_RD1 when wider than eight pixels)
// and emits in S_CAP; the single font port reads one byte a cycle.
// Reset (i_rst_n low, synchronous) clears the cursor, map valid bits and queue
// and sets configuration defaults; font memory stays undefined until written.
// The front end takes transfers while the 4-deep queue has room, as the back
// end draws or o_row stalls; the output register holds a row until taken.
module text_console_glyph_renderer_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tcgr_in_if.sink     i_cmd,
    tcgr_out_if.source  o_row,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [47:0] i_cfg_data
);
    tcgr_pkg::t_cfg r_cfg;
    tcgr_pkg::t_cmd push_data;
    tcgr_pkg::t_hs  push_hs;
    tcgr_pkg::t_cmd pop_data;
    logic           push_ready;
    logic           pop_valid;
    logic           pop_ready;

    // configuration registers; to be written only while idle, not enforced
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fg_bg_rgb       <= 48'd16777215;
            r_cfg.color_layout    <= 27'd8520;
            r_cfg.screen_width_px <= 13'd1024;
            r_cfg.bytes_per_pixel <= 3'd4;
            r_cfg.glyph_width     <= 5'd8;
            r_cfg.glyph_height    <= 6'd16;
            r_cfg.text_cols       <= 10'd128;
            r_cfg.text_rows       <= 9'd48;
        end else if (i_cfg_we) begin
            unique case (tcgr_pkg::t_reg'(i_cfg_idx))
                tcgr_pkg::REG_FG_BG_RGB:    r_cfg.fg_bg_rgb       <= i_cfg_data;
                tcgr_pkg::REG_COLOR_LAYOUT: r_cfg.color_layout    <= i_cfg_data[26:0];
                tcgr_pkg::REG_SCREEN_WIDTH: r_cfg.screen_width_px <= i_cfg_data[12:0];
                tcgr_pkg::REG_BYTES_PER_PX: r_cfg.bytes_per_pixel <= i_cfg_data[2:0];
                tcgr_pkg::REG_GLYPH_WIDTH:  r_cfg.glyph_width     <= i_cfg_data[4:0];
                tcgr_pkg::REG_GLYPH_HEIGHT: r_cfg.glyph_height    <= i_cfg_data[5:0];
                tcgr_pkg::REG_TEXT_COLS:    r_cfg.text_cols       <= i_cfg_data[9:0];
                tcgr_pkg::REG_TEXT_ROWS:    r_cfg.text_rows       <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    // front: accepts, applies map writes, resolves the glyph of a put
    tcgr_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (i_cmd),
        .o_push_data  (push_data),
        .o_push_hs_v  (push_hs),
        .i_push_ready (push_ready)
    );

    // queue between front and back, keeps font writes and puts in order
    tcgr_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_data       (push_data),
        .i_push_hs    (push_hs),
        .o_push_ready (push_ready),
        .o_data       (pop_data),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready)
    );

    // back: font memory, row sequencer, cursor
    tcgr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd       (pop_data),
        .i_cmd_valid (pop_valid),
        .o_cmd_ready (pop_ready),
        .o_row       (o_row)
    );
endmodule
